// ----- hw/rtl/e2q_pkg.sv -----
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants and helpers for the Euler to quaternion pipeline
// Holds the number formats, the CORDIC arctangent table and the stage counts.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int ANGLE_FRAC_BITS = 16;
	localparam int CORDIC_STAGES   = 28;
	localparam int IN_W            = 26;
	localparam int OUT_W           = 32;

	// half angle in units of 2^-(F+1) degrees
	localparam int HA_W = IN_W + 2;
	// CORDIC datapath: Q32 values with guard for growth and sign
	localparam int CW = 36;

	localparam longint LIM_360 = 64'sd360 <<< ANGLE_FRAC_BITS;
	localparam longint H90     = 64'sd90 <<< (ANGLE_FRAC_BITS + 1);
	localparam longint DEG_TO_RAD_Q37 = 64'sd2398762259;
	localparam longint CORDIC_GAIN_Q32 = 64'sd2608131496;
	localparam longint QUARTER_PI_Q32  = 64'sd3373259426;
	localparam longint ONE_Q30 = 64'sd1073741824;

	// quotient of two non-negative constants by shift and subtract
	function automatic longint const_quot(input longint n, input longint d);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((n >>> b) & 64'sd1);
			if (r >= d) begin
				r = r - d;
				q = q | (64'sd1 <<< b);
			end
		end
		return q;
	endfunction

	// arctangent table entry, Q32, evaluated at elaboration
	function automatic longint atan_rom(input int i);
		longint acc;
		longint term;
		int sh;
		acc = 0;
		if (i == 0) begin
			return QUARTER_PI_Q32;
		end
		for (int k = 0; k < 64; k++) begin
			sh = i * (2 * k + 1);
			if (sh >= 62) begin
				break;
			end
			term = const_quot(64'sd1 <<< (62 - sh), longint'(2 * k + 1));
			acc = ((k & 1) == 1) ? acc - term : acc + term;
		end
		return (acc + (64'sd1 <<< 29)) >>> 30;
	endfunction

endpackage

// ----- hw/rtl/euler_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion: heading, pitch and roll to a unit quaternion (Z-Y-X)
// Three CORDIC pipelines give half-angle sine and cosine; a product pipeline
// forms x, y, z and w, each saturated to plus or minus 1.0.
// ----------------------------------------------------------------------------
// Pipeline: the six fixed stages and one register per CORDIC stage lie between
// the accepting edge and strobe.
// Throughput: one word per cycle; busy is held low, the result ports cannot
// stall, so every pipeline stage advances on every clock.
// Reset: arst_n clears all valid bits at once; payload registers keep no reset.
module euler_to_quaternion (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [e2q_pkg::IN_W-1:0]       heading,
	input  logic signed [e2q_pkg::IN_W-1:0]       pitch,
	input  logic signed [e2q_pkg::IN_W-1:0]       roll,
	output logic                                  strobe,
	output logic signed [e2q_pkg::OUT_W-1:0]      quat_x,
	output logic signed [e2q_pkg::OUT_W-1:0]      quat_y,
	output logic signed [e2q_pkg::OUT_W-1:0]      quat_z,
	output logic signed [e2q_pkg::OUT_W-1:0]      quat_w
);
	import e2q_pkg::*;

	localparam int N = CORDIC_STAGES;
	localparam int MW = HA_W + 33;

	assign busy = 1'b0;

	// ---------------- stage 1: saturate, fold, register ----------------
	logic               v_s1;
	logic [HA_W-1:0]    mag_s1 [3];
	logic               neg_s1 [3];
	logic               ncos_s1 [3];

	logic signed [HA_W-1:0] ang_in [3];
	always_comb begin
		ang_in[0] = -HA_W'(heading);
		ang_in[1] = HA_W'(pitch);
		ang_in[2] = HA_W'(roll);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	// clamp to +-360 and fold across 180 degrees
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			logic signed [HA_W-1:0] t;
			logic signed [HA_W-1:0] f;
			logic nc;
			t = ang_in[a];
			if (t > HA_W'(LIM_360)) begin
				t = HA_W'(LIM_360);
			end else if (t < -HA_W'(LIM_360)) begin
				t = -HA_W'(LIM_360);
			end
			nc = 1'b0;
			f = t;
			if (t > HA_W'(H90)) begin
				f = HA_W'(2 * H90) - t;
				nc = 1'b1;
			end else if (t < -HA_W'(H90)) begin
				f = -HA_W'(2 * H90) - t;
				nc = 1'b1;
			end
			neg_s1[a]  <= f[HA_W-1];
			mag_s1[a]  <= f[HA_W-1] ? HA_W'(-f) : HA_W'(f);
			ncos_s1[a] <= nc;
		end
	end

	// ---------------- stage 2: degrees to Q32 radians ----------------
	logic               v_s2;
	logic signed [CW-1:0] z_s2 [3];
	logic               ncos_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			logic [MW-1:0] p;
			logic [CW-1:0] zq;
			p = MW'(mag_s1[a]) * MW'(DEG_TO_RAD_Q37)
				+ (MW'(1) << (ANGLE_FRAC_BITS + 5));
			zq = CW'(p >> (ANGLE_FRAC_BITS + 6));
			z_s2[a]    <= neg_s1[a] ? -$signed(zq) : $signed(zq);
			ncos_s2[a] <= ncos_s1[a];
		end
	end

	// ---------------- CORDIC stages ----------------
	logic               cv_q [N+1];
	logic signed [CW-1:0] cx [N+1][3];
	logic signed [CW-1:0] cy [N+1][3];
	logic signed [CW-1:0] cz [N+1][3];
	logic               cn [N+1][3];

	always_comb begin
		cv_q[0] = v_s2;
		for (int a = 0; a < 3; a++) begin
			cx[0][a] = CW'(CORDIC_GAIN_Q32);
			cy[0][a] = '0;
			cz[0][a] = z_s2[a];
			cn[0][a] = ncos_s2[a];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic signed [CW-1:0] ATAN = CW'(atan_rom(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_q[i+1] <= 1'b0;
			end else begin
				cv_q[i+1] <= cv_q[i];
			end
		end
		// rotate toward zero residual angle
		always_ff @(posedge clk) begin
			for (int a = 0; a < 3; a++) begin
				if (!cz[i][a][CW-1]) begin
					cx[i+1][a] <= cx[i][a] - (cy[i][a] >>> i);
					cy[i+1][a] <= cy[i][a] + (cx[i][a] >>> i);
					cz[i+1][a] <= cz[i][a] - ATAN;
				end else begin
					cx[i+1][a] <= cx[i][a] + (cy[i][a] >>> i);
					cy[i+1][a] <= cy[i][a] - (cx[i][a] >>> i);
					cz[i+1][a] <= cz[i][a] + ATAN;
				end
				cn[i+1][a] <= cn[i][a];
			end
		end
	end

	// ---------------- stage 3: round to Q30 ----------------
	logic               v_s3;
	logic signed [31:0] c_s3 [3];
	logic signed [31:0] s_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= cv_q[N];
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			logic signed [CW-1:0] xc;
			logic signed [CW-1:0] t;
			xc = cn[N][a] ? -cx[N][a] : cx[N][a];
			t = (xc + CW'(2)) >>> 2;
			c_s3[a] <= t[31:0];
			t = (cy[N][a] + CW'(2)) >>> 2;
			s_s3[a] <= t[31:0];
		end
	end

	// ---------------- stage 4: pair products ----------------
	logic               v_s4;
	logic signed [31:0] cycp_s4, sysp_s4, cysp_s4, sycp_s4;
	logic signed [31:0] cr_s4, sr_s4;

	function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
		return 32'(p >>> 30);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cycp_s4 <= mul30(c_s3[0], c_s3[1]);
		sysp_s4 <= mul30(s_s3[0], s_s3[1]);
		cysp_s4 <= mul30(c_s3[0], s_s3[1]);
		sycp_s4 <= mul30(s_s3[0], c_s3[1]);
		cr_s4   <= c_s3[2];
		sr_s4   <= s_s3[2];
	end

	// ---------------- stage 5: Q60 terms ----------------
	logic               v_s5;
	logic signed [63:0] t_s5 [8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		t_s5[0] <= 64'(sycp_s4) * 64'(cr_s4);
		t_s5[1] <= -(64'(cysp_s4) * 64'(sr_s4));
		t_s5[2] <= 64'(cysp_s4) * 64'(cr_s4);
		t_s5[3] <= 64'(sycp_s4) * 64'(sr_s4);
		t_s5[4] <= 64'(cycp_s4) * 64'(sr_s4);
		t_s5[5] <= -(64'(sysp_s4) * 64'(cr_s4));
		t_s5[6] <= 64'(cycp_s4) * 64'(cr_s4);
		t_s5[7] <= 64'(sysp_s4) * 64'(sr_s4);
	end

	// ---------------- stage 6: sum, round, saturate ----------------
	logic               v_s6;
	logic signed [31:0] q_s6 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			logic signed [65:0] s;
			logic signed [65:0] v;
			s = 66'(t_s5[2*c]) + 66'(t_s5[2*c+1]) + (66'sd1 <<< 29);
			v = s >>> 30;
			if (v > 66'(ONE_Q30)) begin
				q_s6[c] <= 32'(ONE_Q30);
			end else if (v < -66'(ONE_Q30)) begin
				q_s6[c] <= -32'(ONE_Q30);
			end else begin
				q_s6[c] <= v[31:0];
			end
		end
	end

	assign strobe = v_s6;
	assign quat_x = q_s6[0];
	assign quat_y = q_s6[1];
	assign quat_z = q_s6[2];
	assign quat_w = q_s6[3];

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ##3 strobe)
		else $error("result word lost in product stages");
	a_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ##(N+1) v_s3)
		else $error("word lost in CORDIC stages");
	a_range_x: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (quat_x <= 32'(ONE_Q30) && quat_x >= -32'(ONE_Q30)))
		else $error("quat_x out of range");
	a_range_w: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (quat_w <= 32'(ONE_Q30) && quat_w >= -32'(ONE_Q30)))
		else $error("quat_w out of range");

endmodule
